[rtl/rmv_pkg.sv]
package rmv_pkg;

    // Fixed widths of the statistics and of the port fields.
    localparam int DATA_W         = 32;
    localparam int VAR_W          = 48;
    localparam int RATE_W         = 16;
    localparam int DEF_FRAC_BITS  = 16;
    localparam logic [RATE_W-1:0] RATE_RESET = 16'd384;

    // Operations that the controller asks of the datapath, one per cycle.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CHECK,
        OP_CLEAR,
        OP_MUL_M1,
        OP_DIVM_LOAD,
        OP_DIV_STEP,
        OP_MEAN_STORE,
        OP_MUL_OM,
        OP_S_CALC,
        OP_MUL_SLO,
        OP_MUL_SHI,
        OP_MUL_VM,
        OP_DIVV_LOAD,
        OP_MUL_NM,
        OP_COMMIT,
        OP_SQ_INIT,
        OP_SQ_STEP,
        OP_MUL_THR,
        OP_RESULT
    } dp_op_t;

    // Controller states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_CLEAR,
        S_MUL_M1,
        S_DIVM_LOAD,
        S_DIVM,
        S_MEAN_STORE,
        S_MUL_OM,
        S_S_CALC,
        S_MUL_SLO,
        S_MUL_SHI,
        S_MUL_VM,
        S_DIVV_LOAD,
        S_DIVV,
        S_MUL_NM,
        S_COMMIT,
        S_SQ_INIT,
        S_SQ,
        S_MUL_THR,
        S_OUT
    } ctl_state_t;

    // Status returned by the datapath.
    typedef struct packed {
        logic missing;
        logic remove;
        logic n_zero;
        logic n_one;
        logic div_last;
        logic sq_last;
    } dp_status_t;

endpackage

[rtl/rmv_datapath.sv]
module rmv_datapath #(
    parameter int FRAC_BITS = rmv_pkg::DEF_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rmv_pkg::dp_op_t                   op,
    output rmv_pkg::dp_status_t               status,
    input  logic                              opcode,
    input  logic signed [rmv_pkg::DATA_W-1:0] sample,
    input  logic                              missing,
    input  logic                              cfg_wr_en,
    input  logic [rmv_pkg::RATE_W-1:0]        cfg_wr_data,
    output logic [rmv_pkg::DATA_W-1:0]        sample_count,
    output logic signed [rmv_pkg::DATA_W-1:0] running_mean,
    output logic [rmv_pkg::DATA_W-1:0]        std_deviation,
    output logic signed [rmv_pkg::DATA_W-1:0] threshold,
    output logic                              underflow_error
);
    import rmv_pkg::*;

    localparam int SQ_W  = 63 - FRAC_BITS;
    localparam int S_W   = ((SQ_W > VAR_W) ? SQ_W : VAR_W) + 1;
    localparam int NUM_W = S_W + 33;
    localparam int X_W   = VAR_W + FRAC_BITS;
    localparam int CMP_W = (X_W > 64) ? X_W : 64;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [63:0] VAR_MAX = 64'((65'd1 << VAR_W) - 65'd1);

    // Statistics state and configuration.
    logic [31:0]        count_reg;
    logic [31:0]        mean_reg;
    logic [VAR_W-1:0]   var_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [4:0]         bit_reg;

    // Working registers.
    logic               opc_reg;
    logic [31:0]        smp_reg;
    logic               miss_reg;
    logic               err_reg;
    logic [32:0]        d_reg;
    logic [63:0]        prod_reg;
    logic               neg_reg;
    logic [31:0]        nmean_reg;
    logic [31:0]        nmag_reg;
    logic [S_W-1:0]     s_reg;
    logic [NUM_W-1:0]   acc_reg;
    logic [NUM_W-1:0]   divn_reg;
    logic [32:0]        rem_reg;
    logic [63:0]        quo_reg;
    logic               over_reg;
    logic [31:0]        root_reg;

    // Result registers.
    logic [31:0]        out_count_reg;
    logic [31:0]        out_mean_reg;
    logic [31:0]        out_sd_reg;
    logic [31:0]        out_thr_reg;
    logic               out_err_reg;

    logic [31:0]        mean_mag;
    logic [31:0]        smp_mag;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        mul_p;
    logic               neg1;
    logic               neg2;
    logic [63:0]        mag;
    logic               mag_neg;
    logic [33:0]        rem_sh;
    logic               div_ge;
    logic [32:0]        rem_new;
    logic [31:0]        nmean_val;
    logic [31:0]        nmag_val;
    logic [NUM_W-1:0]   w_val;
    logic [NUM_W-1:0]   num_val;
    logic [63:0]        q_eff;
    logic [63:0]        m2_val;
    logic [63:0]        var_diff;
    logic [VAR_W-1:0]   var_new;
    logic [31:0]        cand;
    logic [CMP_W-1:0]   x_val;
    logic               sq_ok;
    logic signed [41:0] thr_sum;
    logic [31:0]        thr_val;
    logic [31:0]        count_new;

    // Magnitudes of the stored mean and of the sample.
    assign mean_mag = mean_reg[31] ? (~mean_reg + 32'd1) : mean_reg;
    assign smp_mag  = smp_reg[31] ? (~smp_reg + 32'd1) : smp_reg;

    // Shared 32 by 32 multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            OP_MUL_M1:
            begin
                mul_a = count_reg;
                mul_b = mean_mag;
            end
            OP_MUL_OM:
            begin
                mul_a = mean_mag;
                mul_b = mean_mag;
            end
            OP_MUL_SLO:
            begin
                mul_a = s_reg[31:0];
                mul_b = count_reg;
            end
            OP_MUL_SHI:
            begin
                mul_a = 32'(s_reg[S_W-1:32]);
                mul_b = count_reg;
            end
            OP_MUL_VM:
            begin
                mul_a = smp_mag;
                mul_b = smp_mag;
            end
            OP_MUL_NM:
            begin
                mul_a = nmag_reg;
                mul_b = nmag_reg;
            end
            OP_SQ_STEP:
            begin
                mul_a = cand;
                mul_b = cand;
            end
            OP_MUL_THR:
            begin
                mul_a = 32'(rate_reg);
                mul_b = root_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // Signed sum n*mean +/- sample, as sign and magnitude.
    always_comb
    begin
        neg1 = mean_reg[31];
        neg2 = opc_reg ? (!smp_reg[31] && (smp_reg != 32'd0)) : smp_reg[31];
        if (neg1 == neg2)
        begin
            mag     = prod_reg + 64'(smp_mag);
            mag_neg = neg1;
        end
        else if (prod_reg >= 64'(smp_mag))
        begin
            mag     = prod_reg - 64'(smp_mag);
            mag_neg = neg1;
        end
        else
        begin
            mag     = 64'(smp_mag) - prod_reg;
            mag_neg = neg2;
        end
    end

    // One restoring division step.
    assign rem_sh  = {rem_reg, divn_reg[NUM_W-1]};
    assign div_ge  = rem_sh >= {1'b0, d_reg};
    assign rem_new = div_ge ? 33'(rem_sh - {1'b0, d_reg}) : rem_sh[32:0];

    // New mean saturated to the signed 32-bit range.
    always_comb
    begin
        if (neg_reg)
        begin
            nmag_val  = (quo_reg > 64'h8000_0000) ? 32'h8000_0000 : quo_reg[31:0];
            nmean_val = ~nmag_val + 32'd1;
        end
        else
        begin
            nmag_val  = (quo_reg > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo_reg[31:0];
            nmean_val = nmag_val;
        end
    end

    // Variance numerator: (s*n) +/- sample^2, clamped at zero on removal.
    assign w_val = NUM_W'(prod_reg >> FRAC_BITS);

    always_comb
    begin
        if (!opc_reg)
        begin
            num_val = acc_reg + w_val;
        end
        else if (acc_reg < w_val)
        begin
            num_val = '0;
        end
        else
        begin
            num_val = acc_reg - w_val;
        end
    end

    // New variance from the quotient and the new mean squared.
    assign q_eff    = over_reg ? '1 : quo_reg;
    assign m2_val   = prod_reg >> FRAC_BITS;
    assign var_diff = (q_eff > m2_val) ? (q_eff - m2_val) : 64'd0;
    assign var_new  = (var_diff > VAR_MAX) ? VAR_MAX[VAR_W-1:0] : var_diff[VAR_W-1:0];

    // Square root trial bit.
    assign cand  = root_reg | (32'd1 << bit_reg);
    assign x_val = CMP_W'(var_reg) << FRAC_BITS;
    assign sq_ok = CMP_W'(mul_p) <= x_val;

    // Threshold: mean plus rate times deviation, saturated above.
    always_comb
    begin
        thr_sum = 42'(signed'(mean_reg)) + 42'(prod_reg[47:8]);
        if (thr_sum > 42'sd2147483647)
        begin
            thr_val = 32'h7FFF_FFFF;
        end
        else
        begin
            thr_val = thr_sum[31:0];
        end
    end

    // Count after a committed update.
    always_comb
    begin
        if (opc_reg)
        begin
            count_new = count_reg - 32'd1;
        end
        else if (count_reg == '1)
        begin
            count_new = count_reg;
        end
        else
        begin
            count_new = count_reg + 32'd1;
        end
    end

    // Statistics, configuration and iteration counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            mean_reg  <= '0;
            var_reg   <= '0;
            rate_reg  <= RATE_RESET;
            cnt_reg   <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                rate_reg <= cfg_wr_data;
            end
            case (op)
                OP_CLEAR:
                begin
                    count_reg <= '0;
                    mean_reg  <= '0;
                    var_reg   <= '0;
                end
                OP_DIVM_LOAD:  cnt_reg <= CNT_W'(64);
                OP_DIVV_LOAD:  cnt_reg <= CNT_W'(NUM_W);
                OP_DIV_STEP:   cnt_reg <= cnt_reg - CNT_W'(1);
                OP_COMMIT:
                begin
                    count_reg <= count_new;
                    mean_reg  <= nmean_reg;
                    var_reg   <= var_new;
                end
                OP_SQ_INIT:    bit_reg <= 5'd31;
                OP_SQ_STEP:    bit_reg <= bit_reg - 5'd1;
                default:
                begin
                end
            endcase
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                opc_reg  <= opcode;
                smp_reg  <= sample;
                miss_reg <= missing;
            end
            OP_CHECK:
            begin
                err_reg <= !miss_reg && opc_reg && (count_reg == 32'd0);
                d_reg   <= opc_reg ? (33'(count_reg) - 33'd1) : (33'(count_reg) + 33'd1);
            end
            OP_MUL_M1, OP_MUL_OM, OP_MUL_SLO, OP_MUL_NM, OP_MUL_THR:
            begin
                prod_reg <= mul_p;
            end
            OP_DIVM_LOAD:
            begin
                divn_reg <= NUM_W'(mag) << (NUM_W - 64);
                neg_reg  <= mag_neg;
                rem_reg  <= '0;
                quo_reg  <= '0;
                over_reg <= 1'b0;
            end
            OP_DIV_STEP:
            begin
                divn_reg <= divn_reg << 1;
                rem_reg  <= rem_new;
                quo_reg  <= {quo_reg[62:0], div_ge};
                over_reg <= over_reg | quo_reg[63];
            end
            OP_MEAN_STORE:
            begin
                nmean_reg <= nmean_val;
                nmag_reg  <= nmag_val;
            end
            OP_S_CALC:
            begin
                s_reg <= S_W'(var_reg) + S_W'(prod_reg >> FRAC_BITS);
            end
            OP_MUL_SHI:
            begin
                acc_reg  <= NUM_W'(prod_reg);
                prod_reg <= mul_p;
            end
            OP_MUL_VM:
            begin
                acc_reg  <= acc_reg + (NUM_W'(prod_reg) << 32);
                prod_reg <= mul_p;
            end
            OP_DIVV_LOAD:
            begin
                divn_reg <= num_val;
                rem_reg  <= '0;
                quo_reg  <= '0;
                over_reg <= 1'b0;
            end
            OP_SQ_INIT:
            begin
                root_reg <= '0;
            end
            OP_SQ_STEP:
            begin
                if (sq_ok)
                begin
                    root_reg <= cand;
                end
            end
            OP_RESULT:
            begin
                out_count_reg <= count_reg;
                out_mean_reg  <= mean_reg;
                out_sd_reg    <= root_reg;
                out_thr_reg   <= thr_val;
                out_err_reg   <= err_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Status toward the controller.
    always_comb
    begin
        status.missing  = miss_reg;
        status.remove   = opc_reg;
        status.n_zero   = (count_reg == 32'd0);
        status.n_one    = (count_reg == 32'd1);
        status.div_last = (cnt_reg == CNT_W'(1));
        status.sq_last  = (bit_reg == 5'd0);
    end

    assign sample_count    = out_count_reg;
    assign running_mean    = out_mean_reg;
    assign std_deviation   = out_sd_reg;
    assign threshold       = out_thr_reg;
    assign underflow_error = out_err_reg;

`ifndef SYNTHESIS
    // A removal that empties the statistics leaves them all zero.
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_CLEAR) |=> (count_reg == 32'd0 && mean_reg == 32'd0 && var_reg == '0))
        else $error("clear did not zero the statistics");

    // The count moves by at most one per committed update.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_COMMIT) |=> (count_reg == $past(count_new)))
        else $error("count did not follow the committed update");

    // The error flag is never set for a missing sample.
    a_err_missing: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_CHECK && miss_reg) |=> !err_reg)
        else $error("error flag set for a missing sample");
`endif

endmodule

[rtl/rmv_ctrl.sv]
module rmv_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  rmv_pkg::dp_status_t status,
    output rmv_pkg::dp_op_t     op
);
    import rmv_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.missing)
                begin
                    state_next = S_SQ_INIT;
                end
                else if (!status.remove)
                begin
                    state_next = S_MUL_M1;
                end
                else if (status.n_zero)
                begin
                    state_next = S_SQ_INIT;
                end
                else if (status.n_one)
                begin
                    state_next = S_CLEAR;
                end
                else
                begin
                    state_next = S_MUL_M1;
                end
            end
            S_CLEAR:      state_next = S_SQ_INIT;
            S_MUL_M1:     state_next = S_DIVM_LOAD;
            S_DIVM_LOAD:  state_next = S_DIVM;
            S_DIVM:
            begin
                if (status.div_last)
                begin
                    state_next = S_MEAN_STORE;
                end
            end
            S_MEAN_STORE: state_next = S_MUL_OM;
            S_MUL_OM:     state_next = S_S_CALC;
            S_S_CALC:     state_next = S_MUL_SLO;
            S_MUL_SLO:    state_next = S_MUL_SHI;
            S_MUL_SHI:    state_next = S_MUL_VM;
            S_MUL_VM:     state_next = S_DIVV_LOAD;
            S_DIVV_LOAD:  state_next = S_DIVV;
            S_DIVV:
            begin
                if (status.div_last)
                begin
                    state_next = S_MUL_NM;
                end
            end
            S_MUL_NM:     state_next = S_COMMIT;
            S_COMMIT:     state_next = S_SQ_INIT;
            S_SQ_INIT:    state_next = S_SQ;
            S_SQ:
            begin
                if (status.sq_last)
                begin
                    state_next = S_MUL_THR;
                end
            end
            S_MUL_THR:    state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:      state_next = S_IDLE;
        endcase
    end

    // Datapath operation and handshake outputs.
    always_comb
    begin
        op             = OP_NONE;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                op       = in_valid ? OP_LOAD : OP_NONE;
            end
            S_CHECK:      op = OP_CHECK;
            S_CLEAR:      op = OP_CLEAR;
            S_MUL_M1:     op = OP_MUL_M1;
            S_DIVM_LOAD:  op = OP_DIVM_LOAD;
            S_DIVM:       op = OP_DIV_STEP;
            S_MEAN_STORE: op = OP_MEAN_STORE;
            S_MUL_OM:     op = OP_MUL_OM;
            S_S_CALC:     op = OP_S_CALC;
            S_MUL_SLO:    op = OP_MUL_SLO;
            S_MUL_SHI:    op = OP_MUL_SHI;
            S_MUL_VM:     op = OP_MUL_VM;
            S_DIVV_LOAD:  op = OP_DIVV_LOAD;
            S_DIVV:       op = OP_DIV_STEP;
            S_MUL_NM:     op = OP_MUL_NM;
            S_COMMIT:     op = OP_COMMIT;
            S_SQ_INIT:    op = OP_SQ_INIT;
            S_SQ:         op = OP_SQ_STEP;
            S_MUL_THR:    op = OP_MUL_THR;
            S_OUT:
            begin
                if (out_free)
                begin
                    op             = OP_RESULT;
                    out_valid_next = 1'b1;
                end
            end
            default:      op = OP_NONE;
        endcase
    end

    // State and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    // An accepted item goes straight to the decision step.
    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_CHECK))
        else $error("accepted item did not reach the decision step");

    // A result written to the output register is shown as valid.
    a_result_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result transfer not presented");

    // The root loop ends in the threshold multiply.
    a_sq_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQ && status.sq_last) |=> (state_reg == S_MUL_THR))
        else $error("square root loop did not end correctly");
`endif

endmodule

[rtl/running_mean_variance_add_remove_top.sv]
// Channel   Handshake              Payload
// input     in_valid / in_ready    opcode, sample, missing
// output    out_valid / out_ready  sample_count, running_mean, std_deviation,
//                                  threshold, underflow_error
// config    cfg_wr_en              cfg_wr_data (deviation_rate)
//
// One item at a time. An update runs, from input transfer to result, at
// FRAC_BITS = 16: 64 steps of the radix-2 divider for the mean, NUM_W = S_W + 33 = 82
// steps for the variance, and 32 steps of the square root, plus multiplies and
// bookkeeping; the controller returns to idle before the next input transfer.
// An item that leaves the statistics unchanged runs only the check, root and threshold,
// and a removal that empties the statistics runs a clearing step before the root.
// Reset clears count, mean and variance and sets the rate to 1.5; no clearing pass.
// A result waits in the output register; the next item is taken meanwhile and stalls
// only at its own result transfer.
module running_mean_variance_add_remove_top #(
    parameter int FRAC_BITS = rmv_pkg::DEF_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              opcode,
    input  logic signed [rmv_pkg::DATA_W-1:0] sample,
    input  logic                              missing,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rmv_pkg::DATA_W-1:0]        sample_count,
    output logic signed [rmv_pkg::DATA_W-1:0] running_mean,
    output logic [rmv_pkg::DATA_W-1:0]        std_deviation,
    output logic signed [rmv_pkg::DATA_W-1:0] threshold,
    output logic                              underflow_error,
    input  logic                              cfg_wr_en,
    input  logic [rmv_pkg::RATE_W-1:0]        cfg_wr_data
);
    import rmv_pkg::*;

    dp_op_t     op;
    dp_status_t status;

    // Sequencer.
    rmv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .op        (op)
    );

    // Arithmetic and state.
    rmv_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .op              (op),
        .status          (status),
        .opcode          (opcode),
        .sample          (sample),
        .missing         (missing),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .sample_count    (sample_count),
        .running_mean    (running_mean),
        .std_deviation   (std_deviation),
        .threshold       (threshold),
        .underflow_error (underflow_error)
    );

endmodule
